@@ hdl/pet_pkg.sv @@
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types and constants for the PID error tracker with twiddle tuning.
// ----------------------------------------------------------------------------
package pet_pkg;

   localparam int STEP_WIDTH  = 32;
   localparam int COUNT_WIDTH = 16;
   localparam int INTEG_WIDTH = 32;
   localparam int CSR_WIDTH   = 32;

   localparam logic [COUNT_WIDTH-1:0] WINDOW_LEN_RESET   = 16'd450;
   localparam logic [COUNT_WIDTH-1:0] MAX_ROUNDS_RESET   = 16'd1000;
   localparam logic [STEP_WIDTH-1:0]  INITIAL_STEP_RESET = 32'd32768;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
   localparam logic [STEP_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                    RECIP_SHIFT = 35;

   localparam logic [1:0] GAIN_PROP  = 2'd0;
   localparam logic [1:0] GAIN_LAST  = 2'd2;

   typedef enum logic [1:0] {
      CSR_WINDOW_LEN   = 2'd0,
      CSR_MAX_ROUNDS   = 2'd1,
      CSR_INITIAL_STEP = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0] gain_index;
      logic       tuning_started;
      logic       tried_minus;
   } twiddle_ctrl_type;

endpackage

@@ hdl/pet_twiddle.sv @@
// ----------------------------------------------------------------------------
// pet_twiddle
// One coordinate-descent round over the three gains and their step sizes.
// ----------------------------------------------------------------------------
module pet_twiddle #(
   parameter int GAIN_WIDTH = 32,
   parameter int SUM_WIDTH  = 48
) (
   input  pet_pkg::twiddle_ctrl_type        ctrl_in,
   input  logic signed [GAIN_WIDTH-1:0]     gains_in  [3],
   input  logic [pet_pkg::STEP_WIDTH-1:0]   steps_in  [3],
   input  logic [SUM_WIDTH-1:0]             best_in,
   input  logic [SUM_WIDTH-1:0]             err,
   output pet_pkg::twiddle_ctrl_type        ctrl_out,
   output logic signed [GAIN_WIDTH-1:0]     gains_out [3],
   output logic [pet_pkg::STEP_WIDTH-1:0]   steps_out [3],
   output logic [SUM_WIDTH-1:0]             best_out
);
   import pet_pkg::*;

   // wide enough for gain +/- twice a 32-bit step
   localparam int EXT = ((GAIN_WIDTH > STEP_WIDTH + 2) ? GAIN_WIDTH : STEP_WIDTH + 2) + 1;
   localparam logic signed [EXT-1:0] G_MAX =
      {{(EXT-GAIN_WIDTH+1){1'b0}}, {(GAIN_WIDTH-1){1'b1}}};
   localparam logic signed [EXT-1:0] G_MIN =
      {{(EXT-GAIN_WIDTH+1){1'b1}}, {(GAIN_WIDTH-1){1'b0}}};

   function automatic logic signed [GAIN_WIDTH-1:0] sat_gain(input logic signed [EXT-1:0] v);
      logic signed [GAIN_WIDTH-1:0] r;
      if (v > G_MAX) begin
         r = G_MAX[GAIN_WIDTH-1:0];
      end else if (v < G_MIN) begin
         r = G_MIN[GAIN_WIDTH-1:0];
      end else begin
         r = v[GAIN_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [EXT-1:0] ext_gain(input logic signed [GAIN_WIDTH-1:0] g);
      return EXT'(g);
   endfunction

   function automatic logic signed [EXT-1:0] ext_step(input logic [STEP_WIDTH-1:0] s);
      return $signed(EXT'(s));
   endfunction

   logic [1:0]                  idx;
   logic [1:0]                  nxt;
   logic [STEP_WIDTH-1:0]       step_cur;
   logic [2*STEP_WIDTH-1:0]     recip_prod;
   logic [STEP_WIDTH-1:0]       tenth;
   logic [STEP_WIDTH-1:0]       tenth_x10;
   logic [STEP_WIDTH:0]         up_wide;
   logic [STEP_WIDTH-1:0]       step_up;
   logic [STEP_WIDTH-1:0]       step_dn;
   logic signed [GAIN_WIDTH-1:0] first_gain;
   logic signed [GAIN_WIDTH-1:0] plus_gain;
   logic signed [GAIN_WIDTH-1:0] minus_gain;
   logic signed [GAIN_WIDTH-1:0] adv_gain;

   assign idx      = (ctrl_in.gain_index > GAIN_LAST) ? GAIN_PROP : ctrl_in.gain_index;
   assign nxt      = (idx == GAIN_LAST) ? GAIN_PROP : idx + 2'd1;
   assign step_cur = steps_in[idx];

   // step * 1.1 = s + s/10 ; step * 0.9 = s - ceil(s/10)
   assign recip_prod = (2*STEP_WIDTH)'(step_cur) * (2*STEP_WIDTH)'(RECIP_TEN);
   assign tenth      = STEP_WIDTH'(recip_prod[2*STEP_WIDTH-1:RECIP_SHIFT]);
   assign tenth_x10  = (tenth << 3) + (tenth << 1);
   assign up_wide    = {1'b0, step_cur} + {1'b0, tenth};
   assign step_up    = up_wide[STEP_WIDTH] ? '1 : up_wide[STEP_WIDTH-1:0];
   assign step_dn    = step_cur - tenth - STEP_WIDTH'(tenth_x10 != step_cur);

   assign first_gain = sat_gain(ext_gain(gains_in[GAIN_PROP]) + ext_step(steps_in[GAIN_PROP]));
   assign plus_gain  = sat_gain(ext_gain(gains_in[idx]) + ext_step(step_cur));
   assign minus_gain = sat_gain(ext_gain(gains_in[idx]) - (ext_step(step_cur) <<< 1));
   assign adv_gain   = sat_gain(ext_gain(gains_in[nxt]) + ext_step(steps_in[nxt]));

   always_comb begin
      ctrl_out  = ctrl_in;
      gains_out = gains_in;
      steps_out = steps_in;
      best_out  = best_in;
      if (!ctrl_in.tuning_started) begin
         best_out                = err;
         ctrl_out.gain_index     = GAIN_PROP;
         ctrl_out.tuning_started = 1'b1;
         gains_out[GAIN_PROP]    = first_gain;
      end else if (err < best_in) begin
         best_out             = err;
         steps_out[idx]       = step_up;
         ctrl_out.tried_minus = 1'b0;
         ctrl_out.gain_index  = nxt;
         gains_out[nxt]       = adv_gain;
      end else if (!ctrl_in.tried_minus) begin
         gains_out[idx]       = minus_gain;
         ctrl_out.tried_minus = 1'b1;
      end else begin
         // gain back to center, shrink step, move on to next gain
         gains_out[idx]       = plus_gain;
         steps_out[idx]       = step_dn;
         ctrl_out.tried_minus = 1'b0;
         ctrl_out.gain_index  = nxt;
         gains_out[nxt]       = adv_gain;
      end
   end

endmodule

@@ hdl/pid_error_tracker_twiddle_tuner.sv @@
// ----------------------------------------------------------------------------
// pid_error_tracker_twiddle_tuner
// Tracks error integral, derivative and squared-error sum per window and tunes
// three PID gains by coordinate descent at window ends until the round limit.
// An accepted transaction waits in the input register and moves into the result
// register when the result channel is free to take it.
// Throughput: one sample per cycle while rsp_stall is low; the input register
// squares the sample; the state update and tuning round run as the sample leaves.
// Reset: synchronous, clears all tracker and tuning state and restores the
// register defaults; the block takes samples as soon as reset is released.
// ----------------------------------------------------------------------------
module pid_error_tracker_twiddle_tuner #(
   parameter int ERROR_WIDTH = 16,
   parameter int GAIN_WIDTH  = 32,
   parameter int SUM_WIDTH   = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [ERROR_WIDTH-1:0]        req_error_sample,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pet_pkg::INTEG_WIDTH-1:0] rsp_integral_sum,
   output logic signed [ERROR_WIDTH:0]          rsp_derivative,
   output logic signed [GAIN_WIDTH-1:0]         rsp_gain_prop,
   output logic signed [GAIN_WIDTH-1:0]         rsp_gain_integ,
   output logic signed [GAIN_WIDTH-1:0]         rsp_gain_deriv,
   output logic                                 rsp_window_end,
   output logic                                 rsp_tuning_done,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [pet_pkg::CSR_WIDTH-1:0]        csr_data
);
   import pet_pkg::*;

   localparam int SQ_W  = 2 * ERROR_WIDTH;
   localparam int ACC_W = ((SUM_WIDTH > SQ_W) ? SUM_WIDTH : SQ_W) + 1;
   localparam int INT_X = ((ERROR_WIDTH > INTEG_WIDTH) ? ERROR_WIDTH : INTEG_WIDTH) + 1;
   localparam logic [ACC_W-1:0] SUM_MAX = ACC_W'({SUM_WIDTH{1'b1}});
   localparam logic signed [INT_X-1:0] INT_MAX =
      {{(INT_X-INTEG_WIDTH+1){1'b0}}, {(INTEG_WIDTH-1){1'b1}}};
   localparam logic signed [INT_X-1:0] INT_MIN =
      {{(INT_X-INTEG_WIDTH+1){1'b1}}, {(INTEG_WIDTH-1){1'b0}}};

   // configuration
   logic [COUNT_WIDTH-1:0] window_len_ff, window_len_in;
   logic [COUNT_WIDTH-1:0] max_rounds_ff, max_rounds_in;
   logic [STEP_WIDTH-1:0]  initial_step_ff, initial_step_in;

   // input stage
   logic                          a_valid_ff, a_valid_in;
   logic signed [ERROR_WIDTH-1:0] a_error_ff;
   logic [SQ_W-1:0]               a_square_ff;
   logic [ERROR_WIDTH-1:0]        req_mag;
   logic                          req_take;
   logic                          advance;

   // tracker state
   logic signed [ERROR_WIDTH-1:0] last_error_ff, last_error_in;
   logic                          first_sample_ff, first_sample_in;
   logic signed [INTEG_WIDTH-1:0] integral_ff, integral_in;
   logic [SUM_WIDTH-1:0]          square_sum_ff, square_sum_in;
   logic [COUNT_WIDTH-1:0]        sample_count_ff, sample_count_in;
   logic [COUNT_WIDTH-1:0]        round_count_ff, round_count_in;
   logic                          done_ff, done_in;
   logic [SUM_WIDTH-1:0]          best_ff, best_in;
   twiddle_ctrl_type              ctrl_ff, ctrl_in;
   logic signed [GAIN_WIDTH-1:0]  gains_ff [3];
   logic signed [GAIN_WIDTH-1:0]  gains_in [3];
   logic [STEP_WIDTH-1:0]         steps_ff [3];
   logic [STEP_WIDTH-1:0]         steps_in [3];

   // round results
   twiddle_ctrl_type              rnd_ctrl;
   logic signed [GAIN_WIDTH-1:0]  rnd_gains [3];
   logic [STEP_WIDTH-1:0]         rnd_steps [3];
   logic [SUM_WIDTH-1:0]          rnd_best;

   // per-sample arithmetic
   logic signed [INT_X-1:0]       isum_wide;
   logic signed [INTEG_WIDTH-1:0] isum;
   logic [ACC_W-1:0]              ssum_wide;
   logic [SUM_WIDTH-1:0]          ssum;
   logic [COUNT_WIDTH-1:0]        count_inc;
   logic [COUNT_WIDTH-1:0]        rounds_inc;
   logic                          window_close;
   logic                          round_run;

   // output stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [INTEG_WIDTH-1:0] rsp_isum_ff;
   logic signed [ERROR_WIDTH:0]   rsp_deriv_ff, rsp_deriv_in;
   logic                          rsp_wend_ff;

   // ---------------------------------------------------------------- handshake
   assign advance    = a_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = a_valid_ff & ~advance;
   assign req_take   = req_valid & ~req_stall;
   assign a_valid_in = req_take | (a_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   assign csr_ready  = 1'b1;

   assign req_mag = req_error_sample[ERROR_WIDTH-1] ? (~req_error_sample + 1'b1)
                                                    : req_error_sample;

   // ---------------------------------------------------------------- datapath
   assign isum_wide = INT_X'(integral_ff) + INT_X'(a_error_ff);
   assign isum      = (isum_wide > INT_MAX) ? INT_MAX[INTEG_WIDTH-1:0] :
                      (isum_wide < INT_MIN) ? INT_MIN[INTEG_WIDTH-1:0] :
                      isum_wide[INTEG_WIDTH-1:0];

   assign ssum_wide = ACC_W'(square_sum_ff) + ACC_W'(a_square_ff);
   assign ssum      = (ssum_wide > SUM_MAX) ? '1 : ssum_wide[SUM_WIDTH-1:0];

   assign count_inc    = sample_count_ff + 1'b1;
   assign rounds_inc   = round_count_ff + 1'b1;
   assign window_close = (count_inc == window_len_ff);
   assign round_run    = window_close & ~done_ff;

   assign rsp_deriv_in = first_sample_ff ? '0
                       : (ERROR_WIDTH+1)'(a_error_ff) - (ERROR_WIDTH+1)'(last_error_ff);

   pet_twiddle #(
      .GAIN_WIDTH (GAIN_WIDTH),
      .SUM_WIDTH  (SUM_WIDTH)
   ) u_twiddle (
      .ctrl_in   (ctrl_ff),
      .gains_in  (gains_ff),
      .steps_in  (steps_ff),
      .best_in   (best_ff),
      .err       (ssum),
      .ctrl_out  (rnd_ctrl),
      .gains_out (rnd_gains),
      .steps_out (rnd_steps),
      .best_out  (rnd_best)
   );

   always_comb begin
      last_error_in   = last_error_ff;
      first_sample_in = first_sample_ff;
      integral_in     = integral_ff;
      square_sum_in   = square_sum_ff;
      sample_count_in = sample_count_ff;
      round_count_in  = round_count_ff;
      done_in         = done_ff;
      best_in         = best_ff;
      ctrl_in         = ctrl_ff;
      gains_in        = gains_ff;
      steps_in        = steps_ff;
      window_len_in   = window_len_ff;
      max_rounds_in   = max_rounds_ff;
      initial_step_in = initial_step_ff;

      if (advance) begin
         last_error_in = a_error_ff;
         if (window_close) begin
            integral_in     = '0;
            square_sum_in   = '0;
            sample_count_in = '0;
            first_sample_in = 1'b1;
            if (round_run) begin
               ctrl_in        = rnd_ctrl;
               gains_in       = rnd_gains;
               steps_in       = rnd_steps;
               best_in        = rnd_best;
               round_count_in = rounds_inc;
               if (rounds_inc == max_rounds_ff) begin
                  done_in = 1'b1;
               end
            end
         end else begin
            integral_in     = isum;
            square_sum_in   = ssum;
            sample_count_in = count_inc;
            first_sample_in = 1'b0;
         end
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_LEN: begin
               window_len_in = csr_data[COUNT_WIDTH-1:0];
            end
            CSR_MAX_ROUNDS: begin
               max_rounds_in = csr_data[COUNT_WIDTH-1:0];
            end
            CSR_INITIAL_STEP: begin
               initial_step_in = csr_data[STEP_WIDTH-1:0];
               // steps follow the register only until tuning starts
               if (!ctrl_ff.tuning_started) begin
                  for (int k = 0; k < 3; k++) begin
                     steps_in[k] = csr_data[STEP_WIDTH-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         window_len_ff   <= WINDOW_LEN_RESET;
         max_rounds_ff   <= MAX_ROUNDS_RESET;
         initial_step_ff <= INITIAL_STEP_RESET;
         last_error_ff   <= '0;
         first_sample_ff <= 1'b1;
         integral_ff     <= '0;
         square_sum_ff   <= '0;
         sample_count_ff <= '0;
         round_count_ff  <= '0;
         done_ff         <= 1'b0;
         best_ff         <= '0;
         ctrl_ff         <= '0;
         for (int k = 0; k < 3; k++) begin
            gains_ff[k] <= '0;
            steps_ff[k] <= INITIAL_STEP_RESET;
         end
      end else begin
         a_valid_ff      <= a_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         window_len_ff   <= window_len_in;
         max_rounds_ff   <= max_rounds_in;
         initial_step_ff <= initial_step_in;
         last_error_ff   <= last_error_in;
         first_sample_ff <= first_sample_in;
         integral_ff     <= integral_in;
         square_sum_ff   <= square_sum_in;
         sample_count_ff <= sample_count_in;
         round_count_ff  <= round_count_in;
         done_ff         <= done_in;
         best_ff         <= best_in;
         ctrl_ff         <= ctrl_in;
         gains_ff        <= gains_in;
         steps_ff        <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_error_ff  <= req_error_sample;
         a_square_ff <= SQ_W'(req_mag) * SQ_W'(req_mag);
      end
      if (advance) begin
         rsp_isum_ff  <= isum;
         rsp_deriv_ff <= rsp_deriv_in;
         rsp_wend_ff  <= round_run;
      end
   end

   // gains and done change only when a transaction moves into the output
   // register, so the state registers double as the result fields
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_integral_sum = rsp_isum_ff;
   assign rsp_derivative   = rsp_deriv_ff;
   assign rsp_gain_prop    = gains_ff[0];
   assign rsp_gain_integ   = gains_ff[1];
   assign rsp_gain_deriv   = gains_ff[2];
   assign rsp_window_end   = rsp_wend_ff;
   assign rsp_tuning_done  = done_ff;

endmodule

@@ hdl/pet_checker.sv @@
// ----------------------------------------------------------------------------
// pet_checker
// Port-level checks on the result channel of the twiddle tuner.
// ----------------------------------------------------------------------------
module pet_checker #(
   parameter int GAIN_WIDTH = 32
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [pet_pkg::INTEG_WIDTH-1:0] rsp_integral_sum,
   input logic signed [GAIN_WIDTH-1:0]         rsp_gain_prop,
   input logic signed [GAIN_WIDTH-1:0]         rsp_gain_integ,
   input logic signed [GAIN_WIDTH-1:0]         rsp_gain_deriv,
   input logic                                 rsp_window_end,
   input logic                                 rsp_tuning_done
);

   // stalled result stays valid and keeps its integral sum
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_integral_sum))
      else $error("result transaction changed while stalled");

   // gains move only with a transaction that closed a tuning round
   a_gain_change: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (!$stable(rsp_gain_prop) || !$stable(rsp_gain_integ)
                        || !$stable(rsp_gain_deriv))
      |-> rsp_valid && rsp_window_end)
      else $error("gain changed without a tuning round");

   // done is sticky until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_tuning_done) |-> rsp_tuning_done)
      else $error("tuning done dropped");

   // done rises only with the round that completed the count
   a_done_rise: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_tuning_done) |-> rsp_valid && rsp_window_end)
      else $error("tuning done raised outside a tuning round");

endmodule

bind pid_error_tracker_twiddle_tuner pet_checker #(
   .GAIN_WIDTH (GAIN_WIDTH)
) u_pet_checker (.*);
